>>> hw/rtl/pps_pkg.sv
`timescale 1ns / 1ps
// shared constants and types of the periodic poll scheduler
// no dependencies; imported by the top level, register bank, queue and scan engine

package pps_pkg;

  // due slot indexes are carried at this width on the output port and in accumulator clears
  localparam int SLOT_IDX_W = 3;

  // depth of the scan request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // accumulator clear issued by a period write
  typedef struct packed {
    logic                  en;
    logic [SLOT_IDX_W-1:0] slot;
  } acc_clear_t;

endpackage

>>> hw/rtl/periodic_poll_scheduler_top.sv
`timescale 1ns / 1ps
// top level of the periodic poll scheduler
// depends on pps_pkg, pps_regs, pps_fifo, pps_front and pps_back

// usage
// - config: bus-style port, slot i period at byte address 4*i, low PERIOD_BITS of
//   pwdata kept; a write clears that slot's accumulator and restarts the interval
//   (gcd of nonzero periods) computation; pready is tied high, reads return periods
// - input channel (in_valid/in_ready/ms_passed): one request per millisecond report
// - output channel (out_valid/out_ready/due_slot/last_due): one request per due slot,
//   ascending slot order, last_due set on the final one of a tick
// throughput and flow
// - the front end takes one request a cycle while the interval sequencer is idle
//   and the two-entry scan queue has room
// - each tick that reaches the interval costs one scan over all SLOTS slots, then one
//   emit per due slot, then the scan engine returns to idle
// - after a period write the interval sequencer holds in_ready low until the
//   one-step-per-cycle binary gcd has walked all slots
// reset clears periods, accumulators, elapsed count and interval; no clearing pass
// a stalled receiver holds the output register; the scan engine then waits, the
// queue fills and in_ready drops until results drain

module periodic_poll_scheduler_top import pps_pkg::*; #(
  parameter int SLOTS = 8,
  parameter int PERIOD_BITS = 16,
  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int AW = SIW + 2,
  localparam int CW = PERIOD_BITS + 1
) (
  input  logic                  clk,
  input  logic                  rst,
  // config bus
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AW-1:0]         paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  // tick requests
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            ms_passed,
  // due slot requests
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SLOT_IDX_W-1:0] due_slot,
  output logic                  last_due
);

  logic [SIW-1:0]         scan_idx;
  logic [PERIOD_BITS-1:0] rd_period;
  logic [PERIOD_BITS-1:0] check_interval;
  logic                   busy;
  acc_clear_t             acc_clear;

  logic                   q_push;
  logic [CW-1:0]          q_wr_data;
  logic                   q_pop;
  logic                   q_full;
  logic                   q_valid;
  logic [CW-1:0]          q_rd_data;

  // every bus access completes in its access phase
  assign pready = 1'b1;

  // period registers plus the interval sequencer that stalls input while running
  pps_regs #(
    .SLOTS       (SLOTS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_regs (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .scan_idx       (scan_idx),
    .rd_period      (rd_period),
    .check_interval (check_interval),
    .busy           (busy),
    .acc_clear      (acc_clear)
  );

  // front: saturating elapsed counter, queues a scan once the interval is reached
  pps_front #(
    .PERIOD_BITS (PERIOD_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .ms_passed      (ms_passed),
    .busy           (busy),
    .check_interval (check_interval),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_wr_data)
  );

  // queue of pending scans, each carrying the elapsed time to distribute
  pps_fifo #(
    .WIDTH (CW)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (q_wr_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_valid),
    .rd_data   (q_rd_data)
  );

  // back: one slot per cycle, then drains due slots through the output register
  pps_back #(
    .SLOTS       (SLOTS),
    .PERIOD_BITS (PERIOD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .scan_idx  (scan_idx),
    .rd_period (rd_period),
    .acc_clear (acc_clear),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .due_slot  (due_slot),
    .last_due  (last_due)
  );

endmodule

>>> hw/rtl/pps_regs.sv
`timescale 1ns / 1ps
// period register bank with bus port and iterative interval (gcd) sequencer
// depends on pps_pkg

module pps_regs import pps_pkg::*; #(
  parameter int SLOTS = 8,
  parameter int PERIOD_BITS = 16,
  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int AW = SIW + 2,
  localparam int KW = $clog2(PERIOD_BITS + 1)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [AW-1:0]          paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  input  logic [SIW-1:0]         scan_idx,
  output logic [PERIOD_BITS-1:0] rd_period,
  output logic [PERIOD_BITS-1:0] check_interval,
  output logic                   busy,
  output acc_clear_t             acc_clear
);

  typedef enum logic [2:0] {
    G_IDLE = 3'b001,
    G_LOAD = 3'b010,
    G_RUN  = 3'b100
  } gcd_state_t;

  logic [PERIOD_BITS-1:0] period [SLOTS];
  gcd_state_t             gstate;
  logic [SIW-1:0]         gidx;
  logic [PERIOD_BITS-1:0] g;
  logic [PERIOD_BITS-1:0] a;
  logic [PERIOD_BITS-1:0] b;
  logic [KW-1:0]          k;

  logic [SIW-1:0]         reg_idx;
  logic                   reg_hit;
  logic                   wr_hit;
  logic [SIW-1:0]         rd_idx;
  logic                   gidx_last;
  logic                   gcd_done;
  logic [PERIOD_BITS-1:0] g_res;

  assign reg_idx = paddr[AW-1:2];
  assign reg_hit = ({1'b0, reg_idx} < (SIW + 1)'(SLOTS));
  assign wr_hit  = psel && penable && pwrite && reg_hit;

  assign acc_clear.en   = wr_hit;
  assign acc_clear.slot = SLOT_IDX_W'(reg_idx);

  assign prdata = reg_hit ? 32'(period[reg_idx]) : '0;

  assign busy      = (gstate != G_IDLE);
  assign rd_idx    = busy ? gidx : scan_idx;
  assign rd_period = period[rd_idx];

  assign gidx_last = (gidx == SIW'(SLOTS - 1));
  assign gcd_done  = (a == '0) || (b == '0);
  assign g_res     = PERIOD_BITS'((a | b) << k);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        period[i] <= '0;
      end
    end else if (wr_hit) begin
      period[reg_idx] <= pwdata[PERIOD_BITS-1:0];
    end
  end

  // binary gcd folded over all nonzero periods, one step a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      gstate         <= G_IDLE;
      check_interval <= '0;
    end else if (wr_hit) begin
      gstate <= G_LOAD;
      gidx   <= '0;
      g      <= '0;
    end else begin
      unique case (gstate)
        G_IDLE: begin
        end
        G_LOAD: begin
          if (rd_period != '0) begin
            a      <= g;
            b      <= rd_period;
            k      <= '0;
            gstate <= G_RUN;
          end else if (gidx_last) begin
            check_interval <= g;
            gstate         <= G_IDLE;
          end else begin
            gidx <= gidx + SIW'(1);
          end
        end
        G_RUN: begin
          if (gcd_done) begin
            g <= g_res;
            if (gidx_last) begin
              check_interval <= g_res;
              gstate         <= G_IDLE;
            end else begin
              gidx   <= gidx + SIW'(1);
              gstate <= G_LOAD;
            end
          end else if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + KW'(1);
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (a >= b) begin
            a <= a - b;
          end else begin
            b <= b - a;
          end
        end
        default: begin
          gstate <= G_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/pps_fifo.sv
`timescale 1ns / 1ps
// short request queue between the tick front end and the scan engine
// depends on pps_pkg for its depth

module pps_fifo import pps_pkg::*; #(
  parameter int WIDTH = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic             full,
  output logic             not_empty,
  output logic [WIDTH-1:0] rd_data
);

  localparam int PW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNW = PW + 1;

  logic [WIDTH-1:0] mem [QUEUE_DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CNW-1:0]   count;

  assign full      = (count == CNW'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNW'(1);
      end else if (pop && !push) begin
        count <= count - CNW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/pps_front.sv
`timescale 1ns / 1ps
// tick front end: accepts elapsed-time requests and decides which start a scan
// no package dependencies

module pps_front #(
  parameter int PERIOD_BITS = 16,
  localparam int CW = PERIOD_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             ms_passed,
  input  logic                   busy,
  input  logic [PERIOD_BITS-1:0] check_interval,
  input  logic                   q_full,
  output logic                   q_push,
  output logic [CW-1:0]          q_data
);

  logic [CW-1:0] elapsed;
  logic [CW:0]   sum;
  logic [CW-1:0] sat;
  logic          accept;
  logic          reached;

  assign in_ready = !busy && !q_full;
  assign accept   = in_valid && in_ready;

  assign sum     = (CW + 1)'(elapsed) + (CW + 1)'(ms_passed);
  assign sat     = sum[CW] ? '1 : sum[CW-1:0];
  assign reached = (sat >= CW'(check_interval));

  // with no active slot the scan would report nothing, so it is not queued
  assign q_push = accept && reached && (check_interval != '0);
  assign q_data = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed <= '0;
    end else if (accept) begin
      elapsed <= reached ? '0 : sat;
    end
  end

endmodule

>>> hw/rtl/pps_back.sv
`timescale 1ns / 1ps
// scan engine: walks the slots, updates accumulators, emits due slots
// depends on pps_pkg

module pps_back import pps_pkg::*; #(
  parameter int SLOTS = 8,
  parameter int PERIOD_BITS = 16,
  localparam int SIW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
  localparam int CW = PERIOD_BITS + 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  logic [CW-1:0]          q_data,
  output logic                   q_pop,
  output logic [SIW-1:0]         scan_idx,
  input  logic [PERIOD_BITS-1:0] rd_period,
  input  acc_clear_t             acc_clear,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SLOT_IDX_W-1:0]  due_slot,
  output logic                   last_due
);

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_SCAN = 3'b010,
    B_EMIT = 3'b100
  } back_state_t;

  back_state_t    bstate;
  logic [SIW-1:0] sidx;
  logic [CW-1:0]  ev;
  logic [CW-1:0]  acc [SLOTS];
  logic [SLOTS-1:0] mask;

  logic [CW:0]      acc_sum;
  logic [CW-1:0]    acc_sat;
  logic             active;
  logic             hit;
  logic [SLOTS-1:0] mask_rest;
  logic [SIW-1:0]   low_idx;
  logic             emit;

  assign scan_idx = sidx;
  assign q_pop    = (bstate == B_IDLE) && q_valid;

  assign acc_sum = (CW + 1)'(acc[sidx]) + (CW + 1)'(ev);
  assign acc_sat = acc_sum[CW] ? '1 : acc_sum[CW-1:0];
  assign active  = (rd_period != '0);
  assign hit     = active && (acc_sat >= CW'(rd_period));

  // drop lowest set bit; empty remainder marks the last due slot
  assign mask_rest = mask & (mask - SLOTS'(1));

  always_comb begin
    low_idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mask[i]) begin
        low_idx = SIW'(i);
      end
    end
  end

  assign emit = (bstate == B_EMIT) && (mask != '0) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate    <= B_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        acc[i] <= '0;
      end
    end else begin
      if (acc_clear.en) begin
        acc[acc_clear.slot[SIW-1:0]] <= '0;
      end

      if (emit) begin
        out_valid <= 1'b1;
        due_slot  <= SLOT_IDX_W'(low_idx);
        last_due  <= (mask_rest == '0);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (bstate)
        B_IDLE: begin
          if (q_valid) begin
            ev     <= q_data;
            sidx   <= '0;
            mask   <= '0;
            bstate <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (active) begin
            if (hit) begin
              acc[sidx]  <= '0;
              mask[sidx] <= 1'b1;
            end else begin
              acc[sidx] <= acc_sat;
            end
          end
          if (sidx == SIW'(SLOTS - 1)) begin
            bstate <= B_EMIT;
          end else begin
            sidx <= sidx + SIW'(1);
          end
        end
        B_EMIT: begin
          if (mask == '0) begin
            bstate <= B_IDLE;
          end else if (emit) begin
            mask <= mask_rest;
          end
        end
        default: begin
          bstate <= B_IDLE;
        end
      endcase
    end
  end

endmodule
